@@ sv/fmps_pkg.sv @@
`default_nettype none

package fmps_pkg;

  localparam int VALUE_W = 32;
  localparam int NUM_W   = 32;
  localparam int KEY_W   = VALUE_W + NUM_W;

  // command codes
  localparam logic [1:0] CMD_ARRIVE         = 2'd0;
  localparam logic [1:0] CMD_SERVE_OLDEST   = 2'd1;
  localparam logic [1:0] CMD_SERVE_SMALLEST = 2'd2;

  // status codes
  localparam logic [1:0] ST_QUEUED  = 2'd0;
  localparam logic [1:0] ST_SERVED  = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_REFUSED = 2'd3;

  // one slot of the store
  typedef struct packed {
    logic               valid;
    logic [VALUE_W-1:0] value;
    logic [NUM_W-1:0]   number;
  } entry_t;

  // sequencer to scan unit
  typedef struct packed {
    logic init;
    logic sample;
    logic by_value;
  } scan_ctl_t;

  // scan unit summary back to sequencer
  typedef struct packed {
    logic               found_any;
    logic               found_free;
    logic [VALUE_W-1:0] best_value;
    logic [NUM_W-1:0]   best_number;
  } scan_sum_t;

endpackage

`default_nettype wire

@@ sv/fifo_and_min_priority_server_top.sv @@
// Every command scans all CAPACITY slots of the store through one read port
// and one key comparator: done pulses after the S_SCAN and S_FINISH states.
// busy falls with done, so a new command is taken only after the last completes.
// After rst the store is cleared one slot per cycle (busy high).
// Each result is shown for one cycle on done; the receiver cannot stall it.
`default_nettype none

module fifo_and_min_priority_server_top #(
  parameter int CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command,
  input  wire logic [31:0] value,
  output logic             done,
  output logic [1:0]       status,
  output logic [31:0]      arrival_number
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(CAPACITY);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t                       state;
  logic [CNT_W-1:0]             cnt;
  logic [1:0]                   cmd;
  logic [fmps_pkg::VALUE_W-1:0] val;
  logic [fmps_pkg::NUM_W-1:0]   next_number;
  logic [fmps_pkg::NUM_W-1:0]   next_number_next;

  fmps_pkg::entry_t             mem [CAPACITY];
  fmps_pkg::entry_t             rd_data;
  logic [IDX_W-1:0]             rd_idx;
  logic                         rd_pend;
  logic                         we;
  logic [IDX_W-1:0]             wr_addr;
  fmps_pkg::entry_t             wr_data;

  fmps_pkg::scan_ctl_t          ctl;
  fmps_pkg::scan_sum_t          sum;
  logic [IDX_W-1:0]             best_idx;
  logic [IDX_W-1:0]             free_idx;

  logic [1:0]                   status_next;
  logic [fmps_pkg::NUM_W-1:0]   number_out;

  assign busy = (state != S_IDLE);

  // scan control
  always_comb begin
    ctl.init     = (state == S_IDLE) && start;
    ctl.sample   = (state == S_SCAN) && rd_pend;
    ctl.by_value = (cmd == fmps_pkg::CMD_SERVE_SMALLEST);
  end

  fmps_scan #(.IDX_W(IDX_W)) u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .idx      (rd_idx),
    .entry    (rd_data),
    .sum      (sum),
    .best_idx (best_idx),
    .free_idx (free_idx)
  );

  // command decode at end of scan, plus the store write (clear, queue or serve)
  always_comb begin
    status_next      = fmps_pkg::ST_REFUSED;
    number_out       = '0;
    next_number_next = next_number;
    we               = 1'b0;
    wr_addr          = cnt[IDX_W-1:0];
    wr_data          = '0;
    unique case (state)
      S_CLEAR: begin
        we = 1'b1;
      end
      S_FINISH: begin
        unique case (cmd)
          fmps_pkg::CMD_ARRIVE: begin
            if (sum.found_free && (next_number != '0)) begin
              status_next      = fmps_pkg::ST_QUEUED;
              number_out       = next_number;
              next_number_next = next_number + 32'd1;
              we               = 1'b1;
              wr_addr          = free_idx;
              wr_data          = '{valid: 1'b1, value: val, number: next_number};
            end
          end
          fmps_pkg::CMD_SERVE_OLDEST, fmps_pkg::CMD_SERVE_SMALLEST: begin
            if (sum.found_any) begin
              status_next = fmps_pkg::ST_SERVED;
              number_out  = sum.best_number;
              we          = 1'b1;
              wr_addr     = best_idx;
              wr_data     = '{valid: 1'b0, value: sum.best_value,
                              number: sum.best_number};
            end else begin
              status_next = fmps_pkg::ST_EMPTY;
            end
          end
          default: begin
            status_next = fmps_pkg::ST_REFUSED;
          end
        endcase
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // slot store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[cnt[IDX_W-1:0]];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      cnt         <= '0;
      rd_pend     <= 1'b0;
      next_number <= 32'd1;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          rd_pend <= 1'b0;
          if (start) begin
            cnt   <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_pend <= (cnt != CNT_END);
          if (cnt != CNT_END) begin
            cnt <= cnt + CNT_W'(1);
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          next_number <= next_number_next;
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // transfer payload registers
  always_ff @(posedge clk) begin
    rd_idx <= cnt[IDX_W-1:0];
    if ((state == S_IDLE) && start) begin
      cmd <= command;
      val <= value;
    end
    if (state == S_FINISH) begin
      status         <= status_next;
      arrival_number <= number_out;
    end
  end

  // checks
  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_FINISH))
    else $error("done without a finished scan");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command accepted but block not busy");

  a_number_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == fmps_pkg::ST_QUEUED || status == fmps_pkg::ST_SERVED))
      |-> (arrival_number != '0))
    else $error("zero arrival number on a successful transfer");

  a_counter_sticks: assert property (@(posedge clk) disable iff (rst)
    ($past(next_number) == '0 && !$past(rst)) |-> (next_number == '0))
    else $error("arrival counter left the exhausted state");

endmodule

`default_nettype wire

@@ sv/fmps_scan.sv @@
`default_nettype none

// Running selection over a stream of slots: one key comparator that keeps
// the best occupied slot and the lowest free slot seen so far.
module fmps_scan #(
  parameter int IDX_W = 6
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire fmps_pkg::scan_ctl_t ctl,
  input  wire logic [IDX_W-1:0]   idx,
  input  wire fmps_pkg::entry_t   entry,
  output fmps_pkg::scan_sum_t     sum,
  output logic [IDX_W-1:0]        best_idx,
  output logic [IDX_W-1:0]        free_idx
);

  logic                        found_any;
  logic                        found_free;
  logic [fmps_pkg::VALUE_W-1:0] best_value;
  logic [fmps_pkg::NUM_W-1:0]   best_number;
  logic [fmps_pkg::KEY_W-1:0]   key_cur;
  logic [fmps_pkg::KEY_W-1:0]   key_best;
  logic                         better;

  // value-major key for serve-smallest, number alone for serve-oldest
  always_comb begin
    if (ctl.by_value) begin
      key_cur  = {entry.value, entry.number};
      key_best = {best_value, best_number};
    end else begin
      key_cur  = {{fmps_pkg::VALUE_W{1'b0}}, entry.number};
      key_best = {{fmps_pkg::VALUE_W{1'b0}}, best_number};
    end
    better = !found_any || (key_cur < key_best);
  end

  // flags
  always_ff @(posedge clk) begin
    if (rst || ctl.init) begin
      found_any  <= 1'b0;
      found_free <= 1'b0;
    end else if (ctl.sample) begin
      if (entry.valid) begin
        found_any <= 1'b1;
      end else begin
        found_free <= 1'b1;
      end
    end
  end

  // candidate payload
  always_ff @(posedge clk) begin
    if (ctl.sample && !ctl.init) begin
      if (entry.valid && better) begin
        best_value  <= entry.value;
        best_number <= entry.number;
        best_idx    <= idx;
      end
      if (!entry.valid && !found_free) begin
        free_idx <= idx;
      end
    end
  end

  assign sum = '{found_any:   found_any,
                 found_free:  found_free,
                 best_value:  best_value,
                 best_number: best_number};

endmodule

`default_nettype wire

@@ dv/fifo_and_min_priority_server_top_tb.sv @@
`default_nettype none

module fifo_and_min_priority_server_top_tb;

  localparam int STORE_DEPTH    = 64;
  localparam int CMD_CYCLES     = STORE_DEPTH + 2;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 660;

  // command encoding the block must refuse
  localparam logic [1:0] CMD_UNDEFINED = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] value;
  } server_cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] arrival_number;
  } server_reply_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  command;
  logic [31:0] value;
  logic        done;
  logic [1:0]  status;
  logic [31:0] arrival_number;

  fifo_and_min_priority_server_top #(
    .CAPACITY(STORE_DEPTH)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .value         (value),
    .done          (done),
    .status        (status),
    .arrival_number(arrival_number)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  server_cmd_t   cmd_pending_q[$];
  server_reply_t reply_expect_q[$];

  // shadow copy of the store
  bit        shadow_used  [STORE_DEPTH];
  bit [31:0] shadow_value [STORE_DEPTH];
  bit [31:0] shadow_number[STORE_DEPTH];
  bit [31:0] shadow_next_number = 32'd1;
  int        shadow_count;
  int        deepest_fill;
  int        status_tally[4];

  int          idle_pct;
  int          gen_fill;
  int          gen_budget;
  int          mismatches;
  int          transfers;
  int          drive_mark;
  int unsigned quiet_cycles;

  // Expected reply of one command; updates the shadow store.
  // Counter exhaustion needs 2^32-1 arrivals, so it is modeled but never reached here.
  function automatic server_reply_t serve_or_queue(input server_cmd_t req);
    server_reply_t rep;
    int pick;
    rep.status         = fmps_pkg::ST_REFUSED;
    rep.arrival_number = '0;
    pick               = -1;
    case (req.command)
      fmps_pkg::CMD_ARRIVE: begin
        if (shadow_next_number != 0) begin
          for (int i = 0; i < STORE_DEPTH; i++)
            if (pick < 0 && !shadow_used[i]) pick = i;
          if (pick >= 0) begin
            shadow_used[pick]   = 1'b1;
            shadow_value[pick]  = req.value;
            shadow_number[pick] = shadow_next_number;
            rep.status          = fmps_pkg::ST_QUEUED;
            rep.arrival_number  = shadow_next_number;
            shadow_next_number  = shadow_next_number + 32'd1;
            shadow_count++;
            if (shadow_count > deepest_fill) deepest_fill = shadow_count;
          end
        end
      end
      fmps_pkg::CMD_SERVE_OLDEST, fmps_pkg::CMD_SERVE_SMALLEST: begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
          if (!shadow_used[i]) continue;
          if (pick < 0)
            pick = i;
          else if (req.command == fmps_pkg::CMD_SERVE_SMALLEST) begin
            if (shadow_value[i] < shadow_value[pick] ||
                (shadow_value[i] == shadow_value[pick] &&
                 shadow_number[i] < shadow_number[pick]))
              pick = i;
          end else if (shadow_number[i] < shadow_number[pick])
            pick = i;
        end
        if (pick < 0)
          rep.status = fmps_pkg::ST_EMPTY;
        else begin
          rep.status         = fmps_pkg::ST_SERVED;
          rep.arrival_number = shadow_number[pick];
          shadow_used[pick]  = 1'b0;
          shadow_count--;
        end
      end
      default: ;
    endcase
    status_tally[rep.status]++;
    return rep;
  endfunction

  // Keys: many small values to force ties, plus both ends of the range
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom_range(0, 7);
      4:       return 32'hFFFF_FFF8 + $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  // queue one command and track how full the store will be
  task automatic push_command(input logic [1:0] cmd, input logic [31:0] key);
    server_cmd_t req;
    req.command = cmd;
    req.value   = key;
    cmd_pending_q.insert(cmd_pending_q.size(), req);
    if (cmd == fmps_pkg::CMD_ARRIVE && gen_fill < STORE_DEPTH) gen_fill++;
    if ((cmd == fmps_pkg::CMD_SERVE_OLDEST || cmd == fmps_pkg::CMD_SERVE_SMALLEST) &&
        gen_fill > 0) gen_fill--;
    gen_budget--;
  endtask

  task automatic push_serve();
    push_command($urandom_range(0, 1) ? fmps_pkg::CMD_SERVE_OLDEST
                                      : fmps_pkg::CMD_SERVE_SMALLEST, $urandom);
  endtask

  // Random traffic: runs to full and to empty, and mixed stretches in between
  task automatic load_random(input int count);
    int r;
    gen_budget = count;
    while (gen_budget > 0) begin
      case ($urandom_range(0, 3))
        0: begin
          while (gen_fill < STORE_DEPTH)
            if ($urandom_range(0, 9) == 0) push_serve();
            else push_command(fmps_pkg::CMD_ARRIVE, pick_key());
          repeat ($urandom_range(1, 3)) push_command(fmps_pkg::CMD_ARRIVE, pick_key());
        end
        1: begin
          while (gen_fill > 0)
            if ($urandom_range(0, 9) == 0) push_command(fmps_pkg::CMD_ARRIVE, pick_key());
            else push_serve();
          repeat ($urandom_range(1, 3)) push_serve();
        end
        default: begin
          repeat ($urandom_range(4, 40)) begin
            r = $urandom_range(0, 99);
            if (r < 45)      push_command(fmps_pkg::CMD_ARRIVE, pick_key());
            else if (r < 96) push_serve();
            else             push_command(CMD_UNDEFINED, $urandom);
          end
        end
      endcase
    end
  endtask

  // sender pause: nothing outstanding, then let the block settle
  task automatic wait_drained();
    while (cmd_pending_q.size() != 0 || reply_expect_q.size() != 0) @(negedge clk);
    repeat (CMD_CYCLES + 2) @(negedge clk);
  endtask

  // driver: inputs change on the falling edge; a raised start is held until taken
  always @(negedge clk) begin
    if (rst || cmd_pending_q.size() == 0)
      start <= 1'b0;
    else if ((start && transfers == drive_mark) || $urandom_range(0, 99) >= idle_pct) begin
      start      <= 1'b1;
      command    <= cmd_pending_q[0].command;
      value      <= cmd_pending_q[0].value;
      drive_mark <= transfers;
    end else
      start <= 1'b0;
  end

  // monitor: results checked first, then the command transfer is predicted
  always @(posedge clk) begin
    server_reply_t want;
    server_reply_t pred;
    server_cmd_t   req;
    if (!rst) begin
      if (done) begin
        if (reply_expect_q.size() == 0) begin
          $error("result with none expected: status %0d arrival_number %0d",
                 status, arrival_number);
          mismatches++;
        end else begin
          want = reply_expect_q.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatches++;
          end
          if (arrival_number !== want.arrival_number) begin
            $error("arrival_number: expected %0d, got %0d",
                   want.arrival_number, arrival_number);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        req.command = command;
        req.value   = value;
        void'(cmd_pending_q.pop_front());
        pred = serve_or_queue(req);
        reply_expect_q.insert(reply_expect_q.size(), pred);
        transfers++;
      end
    end
  end

  // watchdog on cycles with no transfer and no result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no activity for %0d cycles", WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // stimulus
  initial begin
    rst      = 1'b1;
    idle_pct = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // directed: empty serves, undefined command, ties and both key extremes
    push_command(fmps_pkg::CMD_SERVE_OLDEST, '0);
    push_command(fmps_pkg::CMD_SERVE_SMALLEST, '1);
    push_command(CMD_UNDEFINED, '0);
    push_command(fmps_pkg::CMD_ARRIVE, '0);
    push_command(fmps_pkg::CMD_ARRIVE, '1);
    push_command(fmps_pkg::CMD_ARRIVE, 32'd5);
    push_command(fmps_pkg::CMD_ARRIVE, 32'd5);
    push_command(fmps_pkg::CMD_ARRIVE, '0);
    push_command(fmps_pkg::CMD_SERVE_SMALLEST, '0);
    push_command(fmps_pkg::CMD_SERVE_SMALLEST, '0);
    push_command(fmps_pkg::CMD_SERVE_SMALLEST, '1);
    push_command(fmps_pkg::CMD_ARRIVE, 32'h8000_0001);
    push_command(fmps_pkg::CMD_SERVE_OLDEST, '1);
    push_command(fmps_pkg::CMD_SERVE_OLDEST, '0);
    push_command(fmps_pkg::CMD_SERVE_SMALLEST, '0);
    push_command(fmps_pkg::CMD_SERVE_OLDEST, '0);
    push_command(CMD_UNDEFINED, '1);
    wait_drained();

    // random phases: back to back, sparse sender, light sender gaps
    idle_pct = 0;
    load_random(PHASE_ITEMS);
    wait_drained();
    idle_pct = 86;
    load_random(PHASE_ITEMS);
    wait_drained();
    idle_pct = 8;
    load_random(PHASE_ITEMS);
    wait_drained();

    if (reply_expect_q.size() != 0)
      $error("%0d results never arrived", reply_expect_q.size());
    $display("%0d commands: %0d queued, %0d served, %0d empty, %0d refused",
             transfers, status_tally[fmps_pkg::ST_QUEUED],
             status_tally[fmps_pkg::ST_SERVED],
             status_tally[fmps_pkg::ST_EMPTY], status_tally[fmps_pkg::ST_REFUSED]);
    $display("store reached %0d of %0d slots; %0d mismatches",
             deepest_fill, STORE_DEPTH, mismatches);
    if (mismatches == 0 && reply_expect_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
